@@ rtl/sli_pkg.sv @@
// Shared constants, status codes and control type for the segment/line intersection block.
package sli_pkg;

   localparam int COORD_WIDTH = 32;

   localparam logic [1:0] STATUS_HIT      = 2'd0;
   localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
   localparam logic [1:0] STATUS_PARALLEL = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE  = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [1:0] status;
   } ctrl_type;

endpackage

@@ rtl/sli_geom.sv @@
// Front end: differences, cross products, determinant, numerator and status (3 stages).
module sli_geom #(
   parameter int W = sli_pkg::COORD_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [W-1:0]   a0x,
   input  logic signed [W-1:0]   a0y,
   input  logic signed [W-1:0]   a1x,
   input  logic signed [W-1:0]   a1y,
   input  logic signed [W-1:0]   b0x,
   input  logic signed [W-1:0]   b0y,
   input  logic signed [W-1:0]   b1x,
   input  logic signed [W-1:0]   b1y,
   output sli_pkg::ctrl_type     out_ctrl,
   output logic [2*W+1:0]        out_den,
   output logic [2*W+1:0]        out_num,
   output logic [W-1:0]          out_mag_x,
   output logic [W-1:0]          out_mag_y,
   output logic                  out_neg_x,
   output logic                  out_neg_y,
   output logic [W-1:0]          out_a0x,
   output logic [W-1:0]          out_a0y
);

   localparam int DW = W + 1;
   localparam int PW = 2 * DW + 1;
   localparam int NW = 2 * DW;

   // stage 1: differences
   logic                 v1_ff;
   logic                 zero1_ff, zero1_in;
   logic signed [DW-1:0] dax_ff, day_ff, dbx_ff, dby_ff, rx_ff, ry_ff;
   logic signed [DW-1:0] dax_in, day_in, dbx_in, dby_in, rx_in, ry_in;
   logic [W-1:0]         a0x1_ff, a0y1_ff;

   assign dax_in = $signed({a1x[W-1], a1x}) - $signed({a0x[W-1], a0x});
   assign day_in = $signed({a1y[W-1], a1y}) - $signed({a0y[W-1], a0y});
   assign dbx_in = $signed({b1x[W-1], b1x}) - $signed({b0x[W-1], b0x});
   assign dby_in = $signed({b1y[W-1], b1y}) - $signed({b0y[W-1], b0y});
   assign rx_in  = $signed({a0x[W-1], a0x}) - $signed({b1x[W-1], b1x});
   assign ry_in  = $signed({a0y[W-1], a0y}) - $signed({b1y[W-1], b1y});
   assign zero1_in = ((a1x == a0x) && (a1y == a0y)) || ((b1x == b0x) && (b1y == b0y));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      dax_ff   <= dax_in;
      day_ff   <= day_in;
      dbx_ff   <= dbx_in;
      dby_ff   <= dby_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      zero1_ff <= zero1_in;
      a0x1_ff  <= a0x;
      a0y1_ff  <= a0y;
   end

   // stage 2: four cross products, direction magnitudes
   logic                 v2_ff;
   logic signed [NW-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [NW-1:0] p1_in, p2_in, p3_in, p4_in;
   logic signed [DW-1:0] absx_in, absy_in;
   logic [W-1:0]         magx2_ff, magy2_ff;
   logic                 negx2_ff, negy2_ff, zero2_ff;
   logic [W-1:0]         a0x2_ff, a0y2_ff;

   assign p1_in   = day_ff * dbx_ff;
   assign p2_in   = dax_ff * dby_ff;
   assign p3_in   = rx_ff * dby_ff;
   assign p4_in   = ry_ff * dbx_ff;
   assign absx_in = dax_ff[DW-1] ? -dax_ff : dax_ff;
   assign absy_in = day_ff[DW-1] ? -day_ff : day_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
      p4_ff    <= p4_in;
      magx2_ff <= absx_in[W-1:0];
      magy2_ff <= absy_in[W-1:0];
      negx2_ff <= dax_ff[DW-1];
      negy2_ff <= day_ff[DW-1];
      zero2_ff <= zero1_ff;
      a0x2_ff  <= a0x1_ff;
      a0y2_ff  <= a0y1_ff;
   end

   // stage 3: determinant, numerator, sign normalization, classification
   logic signed [PW-1:0] den_s, num_s, den_n, num_n;
   logic [1:0]           status_in;
   sli_pkg::ctrl_type    ctrl_ff;
   logic [NW-1:0]        den_ff, num_ff;
   logic [W-1:0]         magx_ff, magy_ff, a0x_ff, a0y_ff;
   logic                 negx_ff, negy_ff;

   assign den_s = $signed({p1_ff[NW-1], p1_ff}) - $signed({p2_ff[NW-1], p2_ff});
   assign num_s = $signed({p3_ff[NW-1], p3_ff}) - $signed({p4_ff[NW-1], p4_ff});
   assign den_n = den_s[PW-1] ? -den_s : den_s;
   assign num_n = den_s[PW-1] ? -num_s : num_s;

   always_comb begin
      priority if (zero2_ff) begin
         status_in = sli_pkg::STATUS_ZERO_LEN;
      end else if (den_s == '0) begin
         status_in = sli_pkg::STATUS_PARALLEL;
      end else if (num_n[PW-1] || (num_n > den_n)) begin
         status_in = sli_pkg::STATUS_OUTSIDE;
      end else begin
         status_in = sli_pkg::STATUS_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff.valid  <= v2_ff;
         ctrl_ff.status <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_n[NW-1:0];
      num_ff  <= num_n[NW-1:0];
      magx_ff <= magx2_ff;
      magy_ff <= magy2_ff;
      negx_ff <= negx2_ff;
      negy_ff <= negy2_ff;
      a0x_ff  <= a0x2_ff;
      a0y_ff  <= a0y2_ff;
   end

   assign out_ctrl  = ctrl_ff;
   assign out_den   = den_ff;
   assign out_num   = num_ff;
   assign out_mag_x = magx_ff;
   assign out_mag_y = magy_ff;
   assign out_neg_x = negx_ff;
   assign out_neg_y = negy_ff;
   assign out_a0x   = a0x_ff;
   assign out_a0y   = a0y_ff;

endmodule

@@ rtl/sli_scale.sv @@
// Numerator times direction magnitude for both axes, as two partial products (2 stages).
module sli_scale #(
   parameter int W = sli_pkg::COORD_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  sli_pkg::ctrl_type   in_ctrl,
   input  logic [2*W+1:0]      in_den,
   input  logic [2*W+1:0]      in_num,
   input  logic [W-1:0]        in_mag_x,
   input  logic [W-1:0]        in_mag_y,
   input  logic                in_neg_x,
   input  logic                in_neg_y,
   input  logic [W-1:0]        in_a0x,
   input  logic [W-1:0]        in_a0y,
   output sli_pkg::ctrl_type   out_ctrl,
   output logic [2*W+1:0]      out_den,
   output logic [3*W+1:0]      out_m_x,
   output logic [3*W+1:0]      out_m_y,
   output logic                out_neg_x,
   output logic                out_neg_y,
   output logic [W-1:0]        out_a0x,
   output logic [W-1:0]        out_a0y
);

   localparam int NW = 2 * W + 2;
   localparam int LW = W + 1;
   localparam int HW = NW - LW;
   localparam int MW = NW + W;

   sli_pkg::ctrl_type  ctrl1_ff, ctrl2_ff;
   logic [LW+W-1:0]    lox_ff, loy_ff, lox_in, loy_in;
   logic [HW+W-1:0]    hix_ff, hiy_ff, hix_in, hiy_in;
   logic [NW-1:0]      den1_ff, den2_ff;
   logic               negx1_ff, negy1_ff, negx2_ff, negy2_ff;
   logic [W-1:0]       a0x1_ff, a0y1_ff, a0x2_ff, a0y2_ff;
   logic [MW-1:0]      mx_ff, my_ff, mx_in, my_in;

   assign lox_in = in_num[LW-1:0] * in_mag_x;
   assign hix_in = in_num[NW-1:LW] * in_mag_x;
   assign loy_in = in_num[LW-1:0] * in_mag_y;
   assign hiy_in = in_num[NW-1:LW] * in_mag_y;

   assign mx_in = MW'(lox_ff) + (MW'(hix_ff) << LW);
   assign my_in = MW'(loy_ff) + (MW'(hiy_ff) << LW);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else begin
         ctrl1_ff <= in_ctrl;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      lox_ff   <= lox_in;
      hix_ff   <= hix_in;
      loy_ff   <= loy_in;
      hiy_ff   <= hiy_in;
      den1_ff  <= in_den;
      negx1_ff <= in_neg_x;
      negy1_ff <= in_neg_y;
      a0x1_ff  <= in_a0x;
      a0y1_ff  <= in_a0y;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      den2_ff  <= den1_ff;
      negx2_ff <= negx1_ff;
      negy2_ff <= negy1_ff;
      a0x2_ff  <= a0x1_ff;
      a0y2_ff  <= a0y1_ff;
   end

   assign out_ctrl  = ctrl2_ff;
   assign out_den   = den2_ff;
   assign out_m_x   = mx_ff;
   assign out_m_y   = my_ff;
   assign out_neg_x = negx2_ff;
   assign out_neg_y = negy2_ff;
   assign out_a0x   = a0x2_ff;
   assign out_a0y   = a0y2_ff;

endmodule

@@ rtl/sli_div.sv @@
// One axis: pipelined restoring divider, one quotient bit per stage, then rounding and offset.
module sli_div #(
   parameter int W = sli_pkg::COORD_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  sli_pkg::ctrl_type   in_ctrl,
   input  logic [2*W+1:0]      in_den,
   input  logic [3*W+1:0]      in_m,
   input  logic                in_neg,
   input  logic [W-1:0]        in_a0,
   output sli_pkg::ctrl_type   out_ctrl,
   output logic [W-1:0]        out_cross
);

   localparam int NW = 2 * W + 2;
   localparam int MW = NW + W;

   sli_pkg::ctrl_type ctrl_ff  [W];
   logic [MW-1:0]     rem_ff   [W];
   logic [W-1:0]      quo_ff   [W];
   logic [NW-1:0]     den_ff   [W];
   logic              neg_ff   [W];
   logic [W-1:0]      a0_ff    [W];

   // quotient is below 2^W since it never exceeds the direction magnitude
   for (genvar s = 0; s < W; s++) begin : g_stage
      sli_pkg::ctrl_type ctrl_pv;
      logic [MW-1:0]     rem_pv, rem_in;
      logic [W-1:0]      quo_pv, quo_in;
      logic [NW-1:0]     den_pv;
      logic              neg_pv;
      logic [W-1:0]      a0_pv;
      logic [MW:0]       diff;

      if (s == 0) begin : g_first
         assign ctrl_pv = in_ctrl;
         assign rem_pv  = in_m;
         assign quo_pv  = '0;
         assign den_pv  = in_den;
         assign neg_pv  = in_neg;
         assign a0_pv   = in_a0;
      end else begin : g_next
         assign ctrl_pv = ctrl_ff[s-1];
         assign rem_pv  = rem_ff[s-1];
         assign quo_pv  = quo_ff[s-1];
         assign den_pv  = den_ff[s-1];
         assign neg_pv  = neg_ff[s-1];
         assign a0_pv   = a0_ff[s-1];
      end

      assign diff   = {1'b0, rem_pv} - ({1'b0, {W{1'b0}}, den_pv} << (W - 1 - s));
      assign rem_in = diff[MW] ? rem_pv : diff[MW-1:0];

      always_comb begin
         quo_in = quo_pv;
         quo_in[W-1-s] = ~diff[MW];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[s] <= '0;
         end else begin
            ctrl_ff[s] <= ctrl_pv;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         quo_ff[s] <= quo_in;
         den_ff[s] <= den_pv;
         neg_ff[s] <= neg_pv;
         a0_ff[s]  <= a0_pv;
      end
   end

   // round half away from zero: magnitude rounds up when 2*rem >= den
   sli_pkg::ctrl_type ctrl_r_ff;
   logic [W:0]        qr_ff, qr_in;
   logic              neg_r_ff;
   logic [W-1:0]      a0_r_ff;
   logic              round_up;

   assign round_up = {rem_ff[W-1][NW-1:0], 1'b0} >= {1'b0, den_ff[W-1]};
   assign qr_in    = {1'b0, quo_ff[W-1]} + {{W{1'b0}}, round_up};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_r_ff <= '0;
      end else begin
         ctrl_r_ff <= ctrl_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      qr_ff    <= qr_in;
      neg_r_ff <= neg_ff[W-1];
      a0_r_ff  <= a0_ff[W-1];
   end

   // apply sign, add start point, zero when not a hit
   sli_pkg::ctrl_type    ctrl_o_ff;
   logic [W-1:0]         cross_ff, cross_in;
   logic signed [W+1:0]  q_mag, q_sgn, sum;

   assign q_mag = $signed({1'b0, qr_ff});
   assign q_sgn = neg_r_ff ? -q_mag : q_mag;
   assign sum   = $signed({{2{a0_r_ff[W-1]}}, a0_r_ff}) + q_sgn;
   assign cross_in = (ctrl_r_ff.status == sli_pkg::STATUS_HIT) ? sum[W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_o_ff <= '0;
      end else begin
         ctrl_o_ff <= ctrl_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      cross_ff <= cross_in;
   end

   assign out_ctrl  = ctrl_o_ff;
   assign out_cross = cross_ff;

endmodule

@@ rtl/segment_line_intersection.sv @@
// Top level: segment A against infinite line B, fully pipelined.
//
// Input: drive the eight coordinates (signed fixed point, COORD_WIDTH bits) on the
// req_ ports with start high for one cycle per transaction. busy is always low, so
// a new transaction may be issued in every cycle.
// Output: rsp_valid is high for exactly one cycle per transaction, in order, with
// rsp_hit, rsp_status (hit, zero length, parallel, outside A) and the crossing
// point rsp_cross_x/rsp_cross_y, which are zero unless the status is a hit.
// Throughput: one per cycle. The pipeline depth is set by the division of num*dA
// by the determinant, done one quotient bit per stage: COORD_WIDTH stages, after
// 3 stages of geometry and 2 of multiplication, followed by a rounding stage and
// an output stage.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module segment_line_intersection #(
   parameter int COORD_WIDTH = sli_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_end_y,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [1:0]                    rsp_status,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y
);

   localparam int W   = COORD_WIDTH;
   localparam int NW  = 2 * W + 2;
   localparam int MW  = NW + W;
   localparam int LAT = W + 7;

   logic accept;

   sli_pkg::ctrl_type g_ctrl, s_ctrl, x_ctrl, y_ctrl;
   logic [NW-1:0]     g_den, g_num, s_den;
   logic [W-1:0]      g_mag_x, g_mag_y, g_a0x, g_a0y, s_a0x, s_a0y;
   logic              g_neg_x, g_neg_y, s_neg_x, s_neg_y;
   logic [MW-1:0]     s_m_x, s_m_y;
   logic [W-1:0]      cross_x, cross_y;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   sli_geom #(.W(W)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .a0x       (req_a_start_x),
      .a0y       (req_a_start_y),
      .a1x       (req_a_end_x),
      .a1y       (req_a_end_y),
      .b0x       (req_b_start_x),
      .b0y       (req_b_start_y),
      .b1x       (req_b_end_x),
      .b1y       (req_b_end_y),
      .out_ctrl  (g_ctrl),
      .out_den   (g_den),
      .out_num   (g_num),
      .out_mag_x (g_mag_x),
      .out_mag_y (g_mag_y),
      .out_neg_x (g_neg_x),
      .out_neg_y (g_neg_y),
      .out_a0x   (g_a0x),
      .out_a0y   (g_a0y)
   );

   sli_scale #(.W(W)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_ctrl   (g_ctrl),
      .in_den    (g_den),
      .in_num    (g_num),
      .in_mag_x  (g_mag_x),
      .in_mag_y  (g_mag_y),
      .in_neg_x  (g_neg_x),
      .in_neg_y  (g_neg_y),
      .in_a0x    (g_a0x),
      .in_a0y    (g_a0y),
      .out_ctrl  (s_ctrl),
      .out_den   (s_den),
      .out_m_x   (s_m_x),
      .out_m_y   (s_m_y),
      .out_neg_x (s_neg_x),
      .out_neg_y (s_neg_y),
      .out_a0x   (s_a0x),
      .out_a0y   (s_a0y)
   );

   sli_div #(.W(W)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_ctrl   (s_ctrl),
      .in_den    (s_den),
      .in_m      (s_m_x),
      .in_neg    (s_neg_x),
      .in_a0     (s_a0x),
      .out_ctrl  (x_ctrl),
      .out_cross (cross_x)
   );

   sli_div #(.W(W)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_ctrl   (s_ctrl),
      .in_den    (s_den),
      .in_m      (s_m_y),
      .in_neg    (s_neg_y),
      .in_a0     (s_a0y),
      .out_ctrl  (y_ctrl),
      .out_cross (cross_y)
   );

   assign rsp_valid   = x_ctrl.valid;
   assign rsp_status  = x_ctrl.status;
   assign rsp_hit     = (x_ctrl.status == sli_pkg::STATUS_HIT);
   assign rsp_cross_x = cross_x;
   assign rsp_cross_y = cross_y;

`ifndef SYNTHESIS
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      x_ctrl == y_ctrl)
      else $error("axis lanes out of step");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("transaction not returned after pipeline latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without a matching request");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("nonzero crossing point on a miss");
`endif

endmodule

@@ tb/sv/tb_segment_line_intersection.sv @@
// Testbench for segment_line_intersection: directed and random segment/line transactions.
`timescale 1ns / 1ps

module tb_segment_line_intersection;

   localparam int W = sli_pkg::COORD_WIDTH;
   localparam int LATENCY = W + 7;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [W-1:0] coord_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] status;
      coord_type  cross_x;
      coord_type  cross_y;
   } crossing_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Exact integer solve; products and quotient kept wide enough to never wrap.
   function automatic coord_type place_coord(input logic signed [W+1:0] origin,
                                             input logic signed [2*W+3:0] num,
                                             input logic signed [W+1:0] delta,
                                             input logic signed [2*W+3:0] den);
      logic signed [3*W+7:0] prod;
      logic [3*W+7:0] mag, quo, rem;
      logic signed [3*W+7:0] q;
      prod = num * delta;
      mag = prod < 0 ? -prod : prod;
      quo = mag / den;
      rem = mag % den;
      if ((rem << 1) >= den) quo = quo + 1;
      q = prod < 0 ? -$signed(quo) : $signed(quo);
      q = q + origin;
      return q[W-1:0];
   endfunction

   function automatic crossing_type solve_crossing(input coord_type ax0, ay0, ax1, ay1,
                                                   input coord_type bx0, by0, bx1, by1);
      logic signed [W+1:0] dax, day, dbx, dby, rx, ry;
      logic signed [2*W+3:0] den, num;
      crossing_type c;
      c = '0;
      dax = ax1 - ax0; day = ay1 - ay0;
      dbx = bx1 - bx0; dby = by1 - by0;
      if ((dax == 0 && day == 0) || (dbx == 0 && dby == 0)) begin
         c.status = sli_pkg::STATUS_ZERO_LEN;
         return c;
      end
      den = day * dbx - dax * dby;
      if (den == 0) begin
         c.status = sli_pkg::STATUS_PARALLEL;
         return c;
      end
      rx = ax0 - bx1; ry = ay0 - by1;
      num = rx * dby - ry * dbx;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num < 0 || num > den) begin
         c.status = sli_pkg::STATUS_OUTSIDE;
         return c;
      end
      c.hit = 1'b1;
      c.status = sli_pkg::STATUS_HIT;
      c.cross_x = place_coord(ax0, num, dax, den);
      c.cross_y = place_coord(ay0, num, day, den);
      return c;
   endfunction

   class crossing_scoreboard;
      crossing_type pending[$];
      int checked = 0;
      int hits = 0;

      function void note_request(crossing_type c);
         pending.push_back(c);
      endfunction

      task check_response(crossing_type got);
         crossing_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transaction", {got.cross_x, got.cross_y}, 64'd0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.hit) hits++;
         if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
         if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
         if (got.cross_x !== want.cross_x)
            report_mismatch("cross_x", 64'(got.cross_x), 64'(want.cross_x));
         if (got.cross_y !== want.cross_y)
            report_mismatch("cross_y", 64'(got.cross_y), 64'(want.cross_y));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_a_start_x = '0, req_a_start_y = '0, req_a_end_x = '0, req_a_end_y = '0;
   coord_type req_b_start_x = '0, req_b_start_y = '0, req_b_end_x = '0, req_b_end_y = '0;
   logic rsp_valid, rsp_hit;
   logic [1:0] rsp_status;
   coord_type rsp_cross_x, rsp_cross_y;

   crossing_scoreboard sb = new();
   int idle_pct = 0;
   int sent = 0;
   longint cycles = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   always #5 clock = ~clock;

   segment_line_intersection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(req_a_start_x), .req_a_start_y(req_a_start_y),
      .req_a_end_x(req_a_end_x), .req_a_end_y(req_a_end_y),
      .req_b_start_x(req_b_start_x), .req_b_start_y(req_b_start_y),
      .req_b_end_x(req_b_end_x), .req_b_end_y(req_b_end_y),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_status(rsp_status),
      .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
      if (!reset && start && !busy) begin
         sb.note_request(solve_crossing(req_a_start_x, req_a_start_y, req_a_end_x,
            req_a_end_y, req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y));
         sent <= sent + 1;
      end
      if (!reset && rsp_valid) begin
         status_seen[rsp_status] <= status_seen[rsp_status] + 1;
         sb.check_response({rsp_hit, rsp_status, rsp_cross_x, rsp_cross_y});
      end
   end

   // Present one transaction from a falling edge and hold it until accepted.
   task automatic send_segments(input coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_a_start_x <= ax0; req_a_start_y <= ay0; req_a_end_x <= ax1; req_a_end_y <= ay1;
      req_b_start_x <= bx0; req_b_start_y <= by0; req_b_end_x <= bx1; req_b_end_y <= by1;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(2048)) - 1024;
         2: return $signed($urandom_range(8 << 16)) - (4 << 16);
         default: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                           : 32'sh80000000 + $urandom_range(3);
      endcase
   endfunction

   task automatic send_random();
      coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, px, py, m;
      int mode, shape;
      mode = $urandom_range(9) < 6 ? 2 : $urandom_range(3);
      shape = $urandom_range(15);
      ax0 = rand_coord(mode); ay0 = rand_coord(mode);
      ax1 = rand_coord(mode); ay1 = rand_coord(mode);
      bx0 = rand_coord(mode); by0 = rand_coord(mode);
      bx1 = rand_coord(mode); by1 = rand_coord(mode);
      case (shape)
         0: begin ax1 = ax0; ay1 = ay0; end
         1: begin bx1 = bx0; by1 = by0; end
         2: begin  // B parallel to A
            m = $signed($urandom_range(6)) - 3;
            bx1 = bx0 + m * (ax1 - ax0); by1 = by0 + m * (ay1 - ay0);
            if (m == 0) bx1 = bx0 + (ax1 - ax0);
         end
         3, 4, 5, 6, 7, 8: begin  // line B through a point on A: mostly hits
            px = ax0 + (($signed($urandom_range(256)) * ((ax1 - ax0) >>> 8)));
            py = ay0 + (($signed($urandom_range(256)) * ((ay1 - ay0) >>> 8)));
            bx0 = px - (bx1 - px); by0 = py - (by1 - py);
         end
         9: begin bx0 = ax1; by0 = ay1; end  // B through an endpoint of A
         default: ;
      endcase
      send_segments(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
   endtask

   localparam coord_type ONE = 32'sh0001_0000;
   localparam coord_type MAXC = 32'sh7fffffff;
   localparam coord_type MINC = 32'sh80000000;

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: clean hit, both endpoints, outside, parallel, collinear, zero length, extremes.
      send_segments(0, 0, 2 * ONE, 0, ONE, -ONE, ONE, ONE);
      send_segments(0, 0, 2 * ONE, 0, 0, -ONE, 0, ONE);
      send_segments(0, 0, 2 * ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE);
      send_segments(0, 0, 2 * ONE, 0, 3 * ONE, -ONE, 3 * ONE, ONE);
      send_segments(0, 0, 2 * ONE, 0, -ONE, -ONE, -ONE, ONE);
      send_segments(0, 0, 2 * ONE, 0, 0, ONE, ONE, ONE);
      send_segments(0, 0, 2 * ONE, 0, 5 * ONE, 0, 7 * ONE, 0);
      send_segments(ONE, ONE, ONE, ONE, 0, 0, ONE, 0);
      send_segments(0, 0, ONE, 0, 3, 3, 3, 3);
      send_segments(5, 5, 5, 5, 7, 7, 7, 7);
      send_segments(0, 0, 3, 0, 1, -1, 2, 1);
      send_segments(0, 0, 3, 1, 1, -5, 1, 5);
      send_segments(0, 0, -3, -1, -1, 5, -1, -5);
      send_segments(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
      send_segments(MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC);
      send_segments(MINC, 0, MAXC, 0, 0, MINC, 1, MAXC);
      send_segments(MAXC, MAXC, MINC, MINC, MAXC, 0, MAXC, -1);
      send_segments(MINC, MAXC, MAXC, MINC, -1, -1, 1, 1);
      send_segments(0, MINC, 0, MAXC, MINC, 7, MAXC, -7);
      send_segments(-1, -1, -1, -1, MAXC, MINC, MAXC, MINC);
      drain_pipeline();

      idle_pct = 23;
      repeat (210) send_random();
      drain_pipeline();  // sender holds off until every result is back
      idle_pct = 65;
      repeat (210) send_random();
      idle_pct = 0;
      repeat (210) send_random();
      drain_pipeline();
      repeat (LATENCY + 5) @(negedge clock);

      $display("Sent %0d, checked %0d transactions: %0d hits, %0d zero length, %0d parallel, %0d outside",
               sent, sb.checked, status_seen[sli_pkg::STATUS_HIT],
               status_seen[sli_pkg::STATUS_ZERO_LEN],
               status_seen[sli_pkg::STATUS_PARALLEL], status_seen[sli_pkg::STATUS_OUTSIDE]);
      $display("Sender gaps at 23%%, 65%% and none; extremes of both coordinates exercised");
      if (error_count == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sli_pkg.sv
rtl/sli_geom.sv
rtl/sli_scale.sv
rtl/sli_div.sv
rtl/segment_line_intersection.sv
tb/sv/tb_segment_line_intersection.sv
